FILE: src/source_text_tokenizer_core_assert.svh
// ----------------------------------------------------------------------------
// source_text_tokenizer_core_assert.svh
// assertion macros used by the tokenizer checker
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_CORE_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_ASSERT_SVH

// same-cycle implication, off while reset is high
`define STT_CHECK_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define STT_CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds through reset
`define STT_CHECK_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// shared types, codes and character classes of the source text tokenizer
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int POS_W  = 16;
  localparam int LINE_W = 16;
  localparam int KIND_W = 5;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [LINE_W-1:0] line_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [7:0]        char_t;

  localparam pos_t  POS_MAX  = '1;
  localparam line_t LINE_MAX = '1;
  localparam line_t LINE_ONE = LINE_W'(1);

  // scan modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_OP    = 3'd1;
  localparam logic [2:0] MODE_NUM   = 3'd2;
  localparam logic [2:0] MODE_IDENT = 3'd3;
  localparam logic [2:0] MODE_STR   = 3'd4;

  // token kinds
  localparam kind_t KIND_DOT        = 5'd0;
  localparam kind_t KIND_COMMA      = 5'd1;
  localparam kind_t KIND_SEMI       = 5'd2;
  localparam kind_t KIND_LPAREN     = 5'd3;
  localparam kind_t KIND_RPAREN     = 5'd4;
  localparam kind_t KIND_LBRACE     = 5'd5;
  localparam kind_t KIND_RBRACE     = 5'd6;
  localparam kind_t KIND_PLUS       = 5'd7;
  localparam kind_t KIND_MINUS      = 5'd8;
  localparam kind_t KIND_STAR       = 5'd9;
  localparam kind_t KIND_SLASH      = 5'd10;
  localparam kind_t KIND_BANG       = 5'd11;
  localparam kind_t KIND_BANG_EQ    = 5'd12;
  localparam kind_t KIND_EQ         = 5'd13;
  localparam kind_t KIND_EQ_EQ      = 5'd14;
  localparam kind_t KIND_GT         = 5'd15;
  localparam kind_t KIND_GE         = 5'd16;
  localparam kind_t KIND_SHR        = 5'd17;
  localparam kind_t KIND_LT         = 5'd18;
  localparam kind_t KIND_LE         = 5'd19;
  localparam kind_t KIND_SHL        = 5'd20;
  localparam kind_t KIND_NUMBER     = 5'd21;
  localparam kind_t KIND_IDENT      = 5'd22;
  localparam kind_t KIND_STRING     = 5'd23;
  localparam kind_t KIND_STR_ERR    = 5'd24;
  localparam kind_t KIND_NONE       = 5'd31;

  // characters
  localparam char_t CH_DOT    = 8'h2E;
  localparam char_t CH_COMMA  = 8'h2C;
  localparam char_t CH_SEMI   = 8'h3B;
  localparam char_t CH_LPAREN = 8'h28;
  localparam char_t CH_RPAREN = 8'h29;
  localparam char_t CH_LBRACE = 8'h7B;
  localparam char_t CH_RBRACE = 8'h7D;
  localparam char_t CH_PLUS   = 8'h2B;
  localparam char_t CH_MINUS  = 8'h2D;
  localparam char_t CH_STAR   = 8'h2A;
  localparam char_t CH_SLASH  = 8'h2F;
  localparam char_t CH_BANG   = 8'h21;
  localparam char_t CH_EQ     = 8'h3D;
  localparam char_t CH_LT     = 8'h3C;
  localparam char_t CH_GT     = 8'h3E;
  localparam char_t CH_QUOTE  = 8'h22;
  localparam char_t CH_NL     = 8'h0A;
  localparam char_t CH_UNDER  = 8'h5F;

  // one result item
  typedef struct packed {
    kind_t kind;
    pos_t  start;
    pos_t  len;
    line_t line;
    logic  last;
  } tok_t;

  // results produced by one byte, in order
  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } push_t;

  // result queue status
  typedef struct packed {
    logic not_empty;
    logic room2;
  } fifo_stat_t;

  function automatic logic is_digit(input char_t b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input char_t b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic is_print(input char_t b);
    return (b >= 8'h20) && (b <= 8'h7E);
  endfunction

  // characters that may open a two-character operator or, for minus, a number
  function automatic kind_t single_kind(input char_t c);
    kind_t k;
    unique case (c)
      CH_EQ:    k = KIND_EQ;
      CH_BANG:  k = KIND_BANG;
      CH_LT:    k = KIND_LT;
      CH_GT:    k = KIND_GT;
      CH_MINUS: k = KIND_MINUS;
      default:  k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t pair_kind(input char_t c, input char_t b);
    kind_t k;
    k = KIND_NONE;
    if (b == CH_EQ) begin
      unique case (c)
        CH_EQ:   k = KIND_EQ_EQ;
        CH_BANG: k = KIND_BANG_EQ;
        CH_LT:   k = KIND_LE;
        CH_GT:   k = KIND_GE;
        default: k = KIND_NONE;
      endcase
    end else if ((c == CH_LT) && (b == CH_LT)) begin
      k = KIND_SHL;
    end else if ((c == CH_GT) && (b == CH_GT)) begin
      k = KIND_SHR;
    end
    return k;
  endfunction

  // punctuation that is a token by itself whenever no open token takes it
  function automatic kind_t punct_kind(input char_t b);
    kind_t k;
    unique case (b)
      CH_DOT:    k = KIND_DOT;
      CH_COMMA:  k = KIND_COMMA;
      CH_SEMI:   k = KIND_SEMI;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_PLUS:   k = KIND_PLUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      default:   k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

FILE: src/stt_scan.sv
// ----------------------------------------------------------------------------
// stt_scan
// scanner state and the per-byte token logic; yields up to two results
// ----------------------------------------------------------------------------
module stt_scan (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  stt_pkg::char_t byte_in,
  input  logic          eoi,
  output stt_pkg::push_t push
);
  import stt_pkg::*;

  // scanner state
  logic [2:0] mode;
  char_t      pend;
  pos_t       tsp;
  pos_t       bpos;
  line_t      line;

  logic [2:0] mode_next;
  char_t      pend_next;
  pos_t       tsp_next;
  pos_t       bpos_next;
  line_t      line_next;

  // intermediate values
  logic [2:0] mode_a;
  logic [2:0] mode_b;
  char_t      pend_b;
  pos_t       tsp_b;
  line_t      line_b;
  pos_t       bpos_inc;
  logic       used;
  logic       v0;
  logic       v1;
  logic       v2;
  tok_t       r0;
  tok_t       r1;
  tok_t       r2;
  kind_t      k_pair;
  kind_t      k_pend;
  kind_t      k_punct;
  kind_t      k_flush;

  assign bpos_inc = (bpos == POS_MAX) ? bpos : bpos + POS_W'(1);
  assign k_pair   = pair_kind(pend, byte_in);
  assign k_pend   = single_kind(pend);
  assign k_punct  = punct_kind(byte_in);
  assign k_flush  = single_kind(pend_b);

  // continue or close the open token
  always_comb begin
    mode_a   = mode;
    used     = 1'b0;
    v0       = 1'b0;
    r0.kind  = KIND_NONE;
    r0.start = tsp;
    r0.len   = bpos - tsp;
    r0.line  = line;
    r0.last  = 1'b0;
    unique case (mode)
      MODE_OP: begin
        if (k_pair != KIND_NONE) begin
          v0      = 1'b1;
          r0.kind = k_pair;
          r0.len  = POS_W'(2);
          mode_a  = MODE_IDLE;
          used    = 1'b1;
        end else if ((pend == CH_MINUS) && is_digit(byte_in)) begin
          mode_a = MODE_NUM;
          used   = 1'b1;
        end else begin
          v0      = (k_pend != KIND_NONE);
          r0.kind = k_pend;
          r0.len  = POS_W'(1);
          mode_a  = MODE_IDLE;
        end
      end
      MODE_NUM: begin
        if (is_digit(byte_in) || (byte_in == CH_DOT)) begin
          used = 1'b1;
        end else begin
          v0      = 1'b1;
          r0.kind = KIND_NUMBER;
          mode_a  = MODE_IDLE;
        end
      end
      MODE_IDENT: begin
        if (is_alpha(byte_in) || is_digit(byte_in) || (byte_in == CH_UNDER)) begin
          used = 1'b1;
        end else begin
          v0      = 1'b1;
          r0.kind = KIND_IDENT;
          mode_a  = MODE_IDLE;
        end
      end
      MODE_STR: begin
        if (byte_in == CH_QUOTE) begin
          v0      = 1'b1;
          r0.kind = KIND_STRING;
          mode_a  = MODE_IDLE;
          used    = 1'b1;
        end else if ((byte_in == CH_NL) || !is_print(byte_in)) begin
          v0      = 1'b1;
          r0.kind = KIND_STR_ERR;
          mode_a  = MODE_IDLE;
        end else begin
          used = 1'b1;
        end
      end
      default: mode_a = MODE_IDLE;
    endcase
  end

  // byte not taken by an open token starts afresh
  always_comb begin
    mode_b   = mode_a;
    pend_b   = pend;
    tsp_b    = tsp;
    line_b   = line;
    v1       = 1'b0;
    r1.kind  = k_punct;
    r1.start = bpos;
    r1.len   = POS_W'(1);
    r1.line  = line;
    r1.last  = 1'b0;
    if (!used) begin
      priority if (k_punct != KIND_NONE) begin
        v1 = 1'b1;
      end else if (single_kind(byte_in) != KIND_NONE) begin
        mode_b = MODE_OP;
        pend_b = byte_in;
        tsp_b  = bpos;
      end else if (is_digit(byte_in)) begin
        mode_b = MODE_NUM;
        tsp_b  = bpos;
      end else if (is_alpha(byte_in)) begin
        mode_b = MODE_IDENT;
        tsp_b  = bpos;
      end else if (byte_in == CH_QUOTE) begin
        mode_b = MODE_STR;
        tsp_b  = bpos_inc;
      end else if (byte_in == CH_NL) begin
        line_b = (line == LINE_MAX) ? line : line + LINE_W'(1);
      end else begin
        // spaces, lone underscores and unknown bytes are skipped
        line_b = line;
      end
    end
  end

  // end of input flushes the open token
  always_comb begin
    v2       = 1'b0;
    r2.kind  = KIND_NONE;
    r2.start = tsp_b;
    r2.len   = bpos_inc - tsp_b;
    r2.line  = line_b;
    r2.last  = 1'b0;
    if (eoi) begin
      unique case (mode_b)
        MODE_OP: begin
          v2      = (k_flush != KIND_NONE);
          r2.kind = k_flush;
          r2.len  = POS_W'(1);
        end
        MODE_NUM: begin
          v2      = 1'b1;
          r2.kind = KIND_NUMBER;
        end
        MODE_IDENT: begin
          v2      = 1'b1;
          r2.kind = KIND_IDENT;
        end
        MODE_STR: begin
          v2      = 1'b1;
          r2.kind = KIND_STR_ERR;
        end
        default: v2 = 1'b0;
      endcase
    end
  end

  // pack the results in order and mark the last one
  always_comb begin
    push.count  = fire ? ({1'b0, v0} + {1'b0, v1} + {1'b0, v2}) : 2'd0;
    push.first  = v0 ? r0 : (v1 ? r1 : r2);
    push.second = (v0 && v1) ? r1 : r2;
    push.first.last  = (push.count == 2'd1);
    push.second.last = 1'b1;
  end

  // next state, back to reset values after the end of input
  always_comb begin
    if (eoi) begin
      mode_next = MODE_IDLE;
      pend_next = '0;
      tsp_next  = '0;
      bpos_next = '0;
      line_next = LINE_ONE;
    end else begin
      mode_next = mode_b;
      pend_next = pend_b;
      tsp_next  = tsp_b;
      bpos_next = bpos_inc;
      line_next = line_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      pend <= '0;
      tsp  <= '0;
      bpos <= '0;
      line <= LINE_ONE;
    end else if (fire) begin
      mode <= mode_next;
      pend <= pend_next;
      tsp  <= tsp_next;
      bpos <= bpos_next;
      line <= line_next;
    end
  end

endmodule

FILE: src/stt_fifo.sv
// ----------------------------------------------------------------------------
// stt_fifo
// four-entry result queue, takes up to two results a cycle, gives one
// ----------------------------------------------------------------------------
module stt_fifo (
  input  logic               clk,
  input  logic               rst,
  input  stt_pkg::push_t     push,
  input  logic               pop,
  output stt_pkg::tok_t      head,
  output stt_pkg::fifo_stat_t stat
);
  import stt_pkg::*;

  localparam int PTR_W = 2;
  localparam int DEPTH = 1 << PTR_W;
  localparam int CNT_W = PTR_W + 1;

  tok_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  assign head           = mem[rd_ptr];
  assign stat.not_empty = (cnt != '0);
  assign stat.room2     = (cnt <= CNT_W'(DEPTH - 2));
  assign cnt_next       = cnt + CNT_W'(push.count) - CNT_W'(pop);

  // entry storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      cnt    <= cnt_next;
    end
  end

endmodule

FILE: src/source_text_tokenizer_core.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_core
// byte-stream lexer: one source byte in, tokens out as kind/start/length/line
// ----------------------------------------------------------------------------
// One source byte is accepted per cycle while in_stall is low. A byte is held
// in an input register, then the scanner logic closes or extends the open
// token and writes its zero, one or two tokens into a four-entry result
// queue, so a token passes through the input register and the queue before
// it is shown. The output side drains one token per cycle while out_stall is
// low; the input stalls only while the queue has fewer than two free entries.
// Tokens are reported when the byte that ends them arrives; end_of_input
// flushes the open token and restarts offsets at 0 and lines at 1.
module source_text_tokenizer_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     byte_in,
  input  logic           end_of_input,
  output logic           out_valid,
  input  logic           out_stall,
  output stt_pkg::kind_t token_kind,
  output stt_pkg::pos_t  token_start,
  output stt_pkg::pos_t  token_length,
  output stt_pkg::line_t line_number,
  output logic           last_of_run
);
  import stt_pkg::*;

  // input register
  logic       s1_valid;
  char_t      s1_byte;
  logic       s1_eoi;
  logic       accept;
  logic       fire;
  push_t      push;
  tok_t       head;
  fifo_stat_t stat;
  logic       pop;

  assign fire     = s1_valid && stat.room2;
  assign in_stall = s1_valid && !stat.room2;
  assign accept   = in_valid && !in_stall;
  assign pop      = stat.not_empty && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= byte_in;
      s1_eoi  <= end_of_input;
    end
  end

  // scanner
  stt_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .byte_in (s1_byte),
    .eoi     (s1_eoi),
    .push    (push)
  );

  // result queue
  stt_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .stat (stat)
  );

  // output request
  assign out_valid    = stat.not_empty;
  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.len;
  assign line_number  = head.line;
  assign last_of_run  = head.last;

endmodule

FILE: src/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// port-level checks on the tokenizer output requests
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_core_assert.svh"

module stt_checker (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_stall,
  input stt_pkg::kind_t token_kind,
  input stt_pkg::pos_t  token_start,
  input stt_pkg::pos_t  token_length,
  input stt_pkg::line_t line_number,
  input logic           last_of_run
);
  import stt_pkg::*;

  // a stalled request keeps its token
  `STT_CHECK_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
    out_valid && $stable(token_kind) && $stable(token_start) &&
    $stable(token_length) && $stable(line_number) && $stable(last_of_run),
    "stalled token changed")

  // no token is shown right after reset
  `STT_CHECK_ALWAYS(a_reset_empty, clk, rst, !out_valid, "token shown after reset")

  // kinds stay within the defined classes
  `STT_CHECK_NOW(a_kind_range, clk, rst, out_valid, token_kind <= KIND_STR_ERR,
    "undefined token kind")

  // operators and punctuation span one or two bytes
  `STT_CHECK_NOW(a_op_length, clk, rst, out_valid && (token_kind <= KIND_SHL),
    (token_length == POS_W'(1)) || (token_length == POS_W'(2)), "operator length wrong")

  // lines count from one
  `STT_CHECK_NOW(a_line_nonzero, clk, rst, out_valid, line_number != '0, "line number zero")

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (.*);
